/* design/jsv_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the JSON syntax validator.
// No dependencies; used by the front, queue, back and top modules.
package jsv_pkg;

  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);

  // Character classes seen by the parser
  typedef enum logic [3:0] {
    CC_OTHER  = 4'd0,
    CC_WS     = 4'd1,
    CC_DIGIT0 = 4'd2,
    CC_DIGIT  = 4'd3,
    CC_LBRACE = 4'd4,
    CC_RBRACE = 4'd5,
    CC_LBRACK = 4'd6,
    CC_RBRACK = 4'd7,
    CC_QUOTE  = 4'd8,
    CC_BSLASH = 4'd9,
    CC_COLON  = 4'd10,
    CC_COMMA  = 4'd11,
    CC_MINUS  = 4'd12,
    CC_PLUS   = 4'd13,
    CC_DOT    = 4'd14,
    CC_EXP    = 4'd15
  } char_class_e;

  // Verdict / error codes
  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_INVALID  = 2'd1,
    ERR_TOO_DEEP = 2'd2
  } err_e;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        end_of_doc;
    char_class_e cls;
  } item_t;

  // Literal text "truefalsenull", indexed by literal progress
  function automatic logic [7:0] lit_char(input logic [3:0] idx);
    logic [7:0] c;
    case (idx)
      4'd0:    c = "t";
      4'd1:    c = "r";
      4'd2:    c = "u";
      4'd3:    c = "e";
      4'd4:    c = "f";
      4'd5:    c = "a";
      4'd6:    c = "l";
      4'd7:    c = "s";
      4'd8:    c = "e";
      4'd9:    c = "n";
      4'd10:   c = "u";
      4'd11:   c = "l";
      4'd12:   c = "l";
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

/* design/jsv_front.sv */
`timescale 1ns / 1ps
// Input stage: accepts bytes, classifies them and registers the request.
// Depends on jsv_pkg.
module jsv_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic [7:0]    in_byte_i,
  input  logic          in_last_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output jsv_pkg::item_t out_item_o
);

  logic           valid_q, valid_d;
  jsv_pkg::item_t item_q;
  jsv_pkg::char_class_e cls;

  always_comb begin
    case (in_byte_i)
      8'h20, 8'h09, 8'h0a, 8'h0d: cls = jsv_pkg::CC_WS;
      "0":      cls = jsv_pkg::CC_DIGIT0;
      "{":      cls = jsv_pkg::CC_LBRACE;
      "}":      cls = jsv_pkg::CC_RBRACE;
      "[":      cls = jsv_pkg::CC_LBRACK;
      "]":      cls = jsv_pkg::CC_RBRACK;
      8'h22:    cls = jsv_pkg::CC_QUOTE;
      8'h5c:    cls = jsv_pkg::CC_BSLASH;
      ":":      cls = jsv_pkg::CC_COLON;
      ",":      cls = jsv_pkg::CC_COMMA;
      "-":      cls = jsv_pkg::CC_MINUS;
      "+":      cls = jsv_pkg::CC_PLUS;
      ".":      cls = jsv_pkg::CC_DOT;
      "e", "E": cls = jsv_pkg::CC_EXP;
      default: begin
        if (in_byte_i inside {["1":"9"]}) cls = jsv_pkg::CC_DIGIT;
        else cls = jsv_pkg::CC_OTHER;
      end
    endcase
  end

  assign in_ready_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign out_item_o  = item_q;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) valid_d = in_valid_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q.data_byte  <= in_byte_i;
      item_q.end_of_doc <= in_last_i;
      item_q.cls        <= cls;
    end
  end

endmodule

/* design/jsv_fifo.sv */
`timescale 1ns / 1ps
// Short request queue between the classifier and the parser.
// Depends on jsv_pkg.
module jsv_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_valid_i,
  output logic           push_ready_o,
  input  jsv_pkg::item_t push_item_i,
  output logic           pop_valid_o,
  input  logic           pop_i,
  output jsv_pkg::item_t pop_item_o
);

  localparam int unsigned CntW = $clog2(jsv_pkg::QueueDepth + 1);

  jsv_pkg::item_t                  mem_q [jsv_pkg::QueueDepth];
  logic [jsv_pkg::QueuePtrW-1:0]   wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]                 count_q, count_d;
  logic                            do_push, do_pop;

  assign push_ready_o = (count_q != CntW'(jsv_pkg::QueueDepth));
  assign pop_valid_o  = (count_q != '0);
  assign pop_item_o   = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_i && pop_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) wr_ptr_d = wr_ptr_q + 1'b1;
    if (do_pop)  rd_ptr_d = rd_ptr_q + 1'b1;
    if (do_push && !do_pop) count_d = count_q + 1'b1;
    else if (!do_push && do_pop) count_d = count_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_item_i;
  end

endmodule

/* design/jsv_back.sv */
`timescale 1ns / 1ps
// Parser: lexer phase, container stack and error latch; registers the verdict.
// Depends on jsv_pkg.
module jsv_back #(
  parameter int unsigned MAX_NEST = 31
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           item_valid_i,
  input  jsv_pkg::item_t item_i,
  output logic           pop_o,
  output logic           res_valid_o,
  input  logic           res_ready_i,
  output logic [1:0]     res_verdict_o
);

  localparam int unsigned Depth = MAX_NEST + 1;
  localparam int unsigned NestW = $clog2(MAX_NEST + 2);
  localparam logic [NestW-1:0] MaxNestL = NestW'(MAX_NEST);

  localparam logic [4:0] PH_VALUE     = 5'd0;
  localparam logic [4:0] PH_ARR_FIRST = 5'd1;
  localparam logic [4:0] PH_OBJ_FIRST = 5'd2;
  localparam logic [4:0] PH_KEY       = 5'd3;
  localparam logic [4:0] PH_COLON     = 5'd4;
  localparam logic [4:0] PH_AFTER     = 5'd5;
  localparam logic [4:0] PH_STR       = 5'd6;
  localparam logic [4:0] PH_STR_ESC   = 5'd7;
  localparam logic [4:0] PH_KSTR      = 5'd8;
  localparam logic [4:0] PH_KSTR_ESC  = 5'd9;
  localparam logic [4:0] PH_LIT       = 5'd10;
  localparam logic [4:0] PH_NUM_SIGN  = 5'd11;
  localparam logic [4:0] PH_NUM_ZERO  = 5'd12;
  localparam logic [4:0] PH_NUM_INT   = 5'd13;
  localparam logic [4:0] PH_NUM_DOT   = 5'd14;
  localparam logic [4:0] PH_NUM_FRAC  = 5'd15;
  localparam logic [4:0] PH_NUM_EXP   = 5'd16;
  localparam logic [4:0] PH_NUM_EXPS  = 5'd17;
  localparam logic [4:0] PH_NUM_EXPD  = 5'd18;

  localparam logic KindArray  = 1'b0;
  localparam logic KindObject = 1'b1;

  logic [4:0]       phase_q, phase_d;
  logic [3:0]       lit_q, lit_d;
  logic [NestW-1:0] nest_q, nest_d;
  logic [Depth-1:0] stack_q, stack_d;   // bit 0 is the innermost container
  jsv_pkg::err_e    err_q, err_d;
  logic             res_valid_q, res_valid_d;
  logic [1:0]       verdict_q;
  logic [1:0]       verdict;

  logic             do_begin, do_after, push, pop, push_kind;
  logic             fail_inv, fail_deep, is_ws;
  logic [3:0]       lit_next;
  logic             slot_free, take;
  jsv_pkg::char_class_e cls;
  logic [7:0]       b;

  assign cls       = item_i.cls;
  assign b         = item_i.data_byte;
  assign is_ws     = (cls == jsv_pkg::CC_WS);
  assign lit_next  = lit_q + 4'd1;
  assign slot_free = !res_valid_q || res_ready_i;
  // a document end needs room in the result register
  assign take      = item_valid_i && (!item_i.end_of_doc || slot_free);
  assign pop_o     = take;

  always_comb begin
    phase_d   = phase_q;
    lit_d     = lit_q;
    do_begin  = 1'b0;
    do_after  = 1'b0;
    push      = 1'b0;
    push_kind = KindArray;
    pop       = 1'b0;
    fail_inv  = 1'b0;
    fail_deep = 1'b0;

    if (err_q == jsv_pkg::ERR_NONE) begin
      case (phase_q)
        PH_VALUE: begin
          if (!is_ws) do_begin = 1'b1;
        end
        PH_ARR_FIRST: begin
          if (cls == jsv_pkg::CC_RBRACK) begin
            pop     = 1'b1;
            phase_d = PH_AFTER;
          end else if (!is_ws) begin
            do_begin = 1'b1;
          end
        end
        PH_OBJ_FIRST, PH_KEY: begin
          if (is_ws) begin
            phase_d = phase_q;
          end else if (phase_q == PH_OBJ_FIRST && cls == jsv_pkg::CC_RBRACE) begin
            pop     = 1'b1;
            phase_d = PH_AFTER;
          end else if (cls == jsv_pkg::CC_QUOTE) begin
            phase_d = PH_KSTR;
          end else begin
            fail_inv = 1'b1;
          end
        end
        PH_COLON: begin
          if (cls == jsv_pkg::CC_COLON) phase_d = PH_VALUE;
          else if (!is_ws) fail_inv = 1'b1;
        end
        PH_AFTER: do_after = 1'b1;
        PH_STR: begin
          if (cls == jsv_pkg::CC_BSLASH) phase_d = PH_STR_ESC;
          else if (cls == jsv_pkg::CC_QUOTE) phase_d = PH_AFTER;
        end
        PH_STR_ESC: phase_d = PH_STR;
        PH_KSTR: begin
          if (cls == jsv_pkg::CC_BSLASH) phase_d = PH_KSTR_ESC;
          else if (cls == jsv_pkg::CC_QUOTE) phase_d = PH_COLON;
        end
        PH_KSTR_ESC: phase_d = PH_KSTR;
        PH_LIT: begin
          if (lit_q < 4'd13 && b == jsv_pkg::lit_char(lit_q)) begin
            lit_d = lit_next;
            if (lit_next inside {4'd4, 4'd9, 4'd13}) phase_d = PH_AFTER;
          end else begin
            fail_inv = 1'b1;
          end
        end
        PH_NUM_SIGN: begin
          if (cls == jsv_pkg::CC_DIGIT0) phase_d = PH_NUM_ZERO;
          else if (cls == jsv_pkg::CC_DIGIT) phase_d = PH_NUM_INT;
          else fail_inv = 1'b1;
        end
        PH_NUM_DOT: begin
          if (cls inside {jsv_pkg::CC_DIGIT0, jsv_pkg::CC_DIGIT}) phase_d = PH_NUM_FRAC;
          else fail_inv = 1'b1;
        end
        PH_NUM_EXP: begin
          if (cls inside {jsv_pkg::CC_PLUS, jsv_pkg::CC_MINUS}) phase_d = PH_NUM_EXPS;
          else if (cls inside {jsv_pkg::CC_DIGIT0, jsv_pkg::CC_DIGIT}) phase_d = PH_NUM_EXPD;
          else fail_inv = 1'b1;
        end
        PH_NUM_EXPS: begin
          if (cls inside {jsv_pkg::CC_DIGIT0, jsv_pkg::CC_DIGIT}) phase_d = PH_NUM_EXPD;
          else fail_inv = 1'b1;
        end
        PH_NUM_ZERO, PH_NUM_INT, PH_NUM_FRAC, PH_NUM_EXPD: begin
          if (phase_q != PH_NUM_ZERO &&
              cls inside {jsv_pkg::CC_DIGIT0, jsv_pkg::CC_DIGIT}) begin
            phase_d = phase_q;
          end else if ((phase_q == PH_NUM_ZERO || phase_q == PH_NUM_INT) &&
                       cls == jsv_pkg::CC_DOT) begin
            phase_d = PH_NUM_DOT;
          end else if (phase_q != PH_NUM_EXPD && cls == jsv_pkg::CC_EXP) begin
            phase_d = PH_NUM_EXP;
          end else begin
            // the terminating byte is judged as a byte after a value
            do_after = 1'b1;
          end
        end
        default: fail_inv = 1'b1;
      endcase

      if (do_begin) begin
        if (nest_q > MaxNestL) begin
          fail_deep = 1'b1;
        end else begin
          // nest_q <= MAX_NEST here, so the stack always has room
          case (cls)
            jsv_pkg::CC_LBRACE: begin
              push      = 1'b1;
              push_kind = KindObject;
              phase_d   = PH_OBJ_FIRST;
            end
            jsv_pkg::CC_LBRACK: begin
              push      = 1'b1;
              push_kind = KindArray;
              phase_d   = PH_ARR_FIRST;
            end
            jsv_pkg::CC_QUOTE:  phase_d = PH_STR;
            jsv_pkg::CC_MINUS:  phase_d = PH_NUM_SIGN;
            jsv_pkg::CC_DIGIT0: phase_d = PH_NUM_ZERO;
            jsv_pkg::CC_DIGIT:  phase_d = PH_NUM_INT;
            default: begin
              if (b == "t") begin
                lit_d   = 4'd1;
                phase_d = PH_LIT;
              end else if (b == "f") begin
                lit_d   = 4'd5;
                phase_d = PH_LIT;
              end else if (b == "n") begin
                lit_d   = 4'd10;
                phase_d = PH_LIT;
              end else begin
                fail_inv = 1'b1;
              end
            end
          endcase
        end
      end

      if (do_after) begin
        phase_d = PH_AFTER;
        if (!is_ws) begin
          if (nest_q == '0) begin
            fail_inv = 1'b1;
          end else if (cls == jsv_pkg::CC_COMMA) begin
            phase_d = (stack_q[0] == KindObject) ? PH_KEY : PH_VALUE;
          end else if ((stack_q[0] == KindArray && cls == jsv_pkg::CC_RBRACK) ||
                       (stack_q[0] == KindObject && cls == jsv_pkg::CC_RBRACE)) begin
            pop = 1'b1;
          end else begin
            fail_inv = 1'b1;
          end
        end
      end
    end
  end

  always_comb begin
    nest_d  = nest_q;
    stack_d = stack_q;
    err_d   = err_q;
    if (push) begin
      nest_d  = nest_q + 1'b1;
      stack_d = {stack_q[Depth-2:0], push_kind};
    end else if (pop) begin
      nest_d  = nest_q - 1'b1;
      stack_d = {stack_q[Depth-1], stack_q[Depth-1:1]};
    end
    if (fail_deep) err_d = jsv_pkg::ERR_TOO_DEEP;
    else if (fail_inv) err_d = jsv_pkg::ERR_INVALID;
  end

  always_comb begin
    verdict = err_d;
    if (err_d == jsv_pkg::ERR_NONE &&
        (nest_d != '0 || !(phase_d == PH_AFTER || phase_d == PH_NUM_ZERO ||
                           phase_d == PH_NUM_INT || phase_d == PH_NUM_FRAC ||
                           phase_d == PH_NUM_EXPD)))
      verdict = jsv_pkg::ERR_INVALID;
  end

  always_comb begin
    res_valid_d = res_valid_q;
    if (res_ready_i) res_valid_d = 1'b0;
    if (take && item_i.end_of_doc) res_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_VALUE;
      lit_q       <= '0;
      nest_q      <= '0;
      err_q       <= jsv_pkg::ERR_NONE;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
      if (take) begin
        if (item_i.end_of_doc) begin
          // clear for the next document
          phase_q <= PH_VALUE;
          lit_q   <= '0;
          nest_q  <= '0;
          err_q   <= jsv_pkg::ERR_NONE;
        end else begin
          phase_q <= phase_d;
          lit_q   <= lit_d;
          nest_q  <= nest_d;
          err_q   <= err_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) stack_q <= stack_d;
    if (take && item_i.end_of_doc) verdict_q <= verdict;
  end

  assign res_valid_o   = res_valid_q;
  assign res_verdict_o = verdict_q;

endmodule

/* design/json_syntax_validator.sv */
`timescale 1ns / 1ps
// Channel   Dir  Payload                               Accept
// s_axis    in   tdata[7:0] data_byte, tlast end_of_doc tvalid & tready
// m_axis    out  tdata[1:0] verdict, [7:2] zero          tvalid & tready
//
// One byte per cycle sustained unless a final byte waits on a stalled output,
// which holds up the bytes behind it. The front register feeds a four-entry
// queue; the parser takes the queue head and registers the verdict.
// rst_ni clears phase, nesting, error latch, queue and output valid at once.
// Top level: classifier front, request queue, parser back. Depends on jsv_pkg.
module json_syntax_validator #(
  parameter int unsigned MAX_NEST = 31
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,   // [7:0] data_byte
  input  logic       s_axis_tlast_i,
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o    // [1:0] verdict, [7:2] zero
);

  logic           fr_valid, fr_ready;
  jsv_pkg::item_t fr_item;
  logic           q_valid, q_pop;
  jsv_pkg::item_t q_item;
  logic [1:0]     verdict;

  jsv_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .in_byte_i  (s_axis_tdata_i),
    .in_last_i  (s_axis_tlast_i),
    .out_valid_o(fr_valid),
    .out_ready_i(fr_ready),
    .out_item_o (fr_item)
  );

  jsv_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(fr_valid),
    .push_ready_o(fr_ready),
    .push_item_i (fr_item),
    .pop_valid_o (q_valid),
    .pop_i       (q_pop),
    .pop_item_o  (q_item)
  );

  jsv_back #(
    .MAX_NEST(MAX_NEST)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (q_valid),
    .item_i       (q_item),
    .pop_o        (q_pop),
    .res_valid_o  (m_axis_tvalid_o),
    .res_ready_i  (m_axis_tready_i),
    .res_verdict_o(verdict)
  );

  assign m_axis_tdata_o = {6'd0, verdict};

endmodule

/* tb/json_verdict_checker.sv */
`timescale 1ns / 1ps
// Scoreboard for the JSON syntax validator: follows both stream channels,
// tracks the grammar of every accepted byte and checks each verdict in order.
// Depends on jsv_pkg for the verdict codes.
module json_verdict_checker #(
  parameter int unsigned MAX_NEST = 31
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_tvalid_i,
  input  logic       s_tready_i,
  input  logic [7:0] s_tdata_i,   // [7:0] data_byte
  input  logic       s_tlast_i,
  input  logic       m_tvalid_i,
  input  logic       m_tready_i,
  input  logic [7:0] m_tdata_i,   // [1:0] verdict, [7:2] zero
  output int         fail_count_o,
  output int         pending_o
);

  typedef enum logic [4:0] {
    LX_VALUE,
    LX_ARR_OPEN,
    LX_OBJ_OPEN,
    LX_KEY,
    LX_COLON,
    LX_AFTER,
    LX_STR,
    LX_STR_ESC,
    LX_KEY_STR,
    LX_KEY_ESC,
    LX_LIT,
    LX_MINUS,
    LX_LEAD_ZERO,
    LX_INT,
    LX_POINT,
    LX_FRAC,
    LX_EXP,
    LX_EXP_SIGN,
    LX_EXP_DIGIT
  } lex_phase_e;

  localparam logic KindArray  = 1'b0;
  localparam logic KindObject = 1'b1;
  localparam logic [8*13-1:0] LitText = "truefalsenull";

  lex_phase_e    phase;
  logic [3:0]    lit_pos;
  logic [5:0]    depth;
  logic          kinds [32];
  jsv_pkg::err_e first_err;
  jsv_pkg::err_e verdicts_due [$];

  function automatic bit is_space(input logic [7:0] b);
    return b == " " || b == 8'h09 || b == 8'h0A || b == 8'h0D;
  endfunction

  function automatic bit is_digit(input logic [7:0] b);
    return b >= "0" && b <= "9";
  endfunction

  function automatic void flag(input jsv_pkg::err_e code);
    if (first_err == jsv_pkg::ERR_NONE) begin
      first_err = code;
    end
  endfunction

  function automatic void clear_doc();
    phase     = LX_VALUE;
    lit_pos   = 4'd0;
    depth     = 6'd0;
    first_err = jsv_pkg::ERR_NONE;
  endfunction

  function automatic void enter_value(input logic [7:0] b);
    if (depth > MAX_NEST) begin
      flag(jsv_pkg::ERR_TOO_DEEP);
    end else begin
      case (b)
        "{", "[": begin
          kinds[depth[4:0]] = (b == "{") ? KindObject : KindArray;
          phase = (b == "{") ? LX_OBJ_OPEN : LX_ARR_OPEN;
          depth = depth + 6'd1;
        end
        "\"": phase = LX_STR;
        "t": begin
          lit_pos = 4'd1;
          phase   = LX_LIT;
        end
        "f": begin
          lit_pos = 4'd5;
          phase   = LX_LIT;
        end
        "n": begin
          lit_pos = 4'd10;
          phase   = LX_LIT;
        end
        "-": phase = LX_MINUS;
        "0": phase = LX_LEAD_ZERO;
        default: begin
          if (is_digit(b)) begin
            phase = LX_INT;
          end else begin
            flag(jsv_pkg::ERR_INVALID);
          end
        end
      endcase
    end
  endfunction

  // Judge the byte that follows a complete value.
  function automatic void follow_value(input logic [7:0] b);
    logic kind;
    phase = LX_AFTER;
    if (!is_space(b)) begin
      if (depth == 6'd0) begin
        flag(jsv_pkg::ERR_INVALID);
      end else begin
        kind = kinds[depth[4:0] - 5'd1];
        if (b == ",") begin
          phase = (kind == KindObject) ? LX_KEY : LX_VALUE;
        end else if ((kind == KindArray && b == "]") || (kind == KindObject && b == "}")) begin
          depth = depth - 6'd1;
        end else begin
          flag(jsv_pkg::ERR_INVALID);
        end
      end
    end
  endfunction

  function automatic void parse_byte(input logic [7:0] b);
    int k;
    case (phase)
      LX_VALUE: begin
        if (!is_space(b)) begin
          enter_value(b);
        end
      end
      LX_ARR_OPEN: begin
        if (b == "]") begin
          depth = depth - 6'd1;
          phase = LX_AFTER;
        end else if (!is_space(b)) begin
          enter_value(b);
        end
      end
      LX_OBJ_OPEN, LX_KEY: begin
        if (phase == LX_OBJ_OPEN && b == "}") begin
          depth = depth - 6'd1;
          phase = LX_AFTER;
        end else if (b == "\"") begin
          phase = LX_KEY_STR;
        end else if (!is_space(b)) begin
          flag(jsv_pkg::ERR_INVALID);
        end
      end
      LX_COLON: begin
        if (b == ":") begin
          phase = LX_VALUE;
        end else if (!is_space(b)) begin
          flag(jsv_pkg::ERR_INVALID);
        end
      end
      LX_AFTER: follow_value(b);
      LX_STR: begin
        if (b == "\\") begin
          phase = LX_STR_ESC;
        end else if (b == "\"") begin
          phase = LX_AFTER;
        end
      end
      LX_STR_ESC: phase = LX_STR;
      LX_KEY_STR: begin
        if (b == "\\") begin
          phase = LX_KEY_ESC;
        end else if (b == "\"") begin
          phase = LX_COLON;
        end
      end
      LX_KEY_ESC: phase = LX_KEY_STR;
      LX_LIT: begin
        k = lit_pos;
        if (k < 13 && b == LitText[8*(12-k) +: 8]) begin
          lit_pos = lit_pos + 4'd1;
          if (lit_pos == 4'd4 || lit_pos == 4'd9 || lit_pos == 4'd13) begin
            phase = LX_AFTER;
          end
        end else begin
          flag(jsv_pkg::ERR_INVALID);
        end
      end
      LX_MINUS: begin
        if (b == "0") begin
          phase = LX_LEAD_ZERO;
        end else if (is_digit(b)) begin
          phase = LX_INT;
        end else begin
          flag(jsv_pkg::ERR_INVALID);
        end
      end
      LX_POINT: begin
        if (is_digit(b)) begin
          phase = LX_FRAC;
        end else begin
          flag(jsv_pkg::ERR_INVALID);
        end
      end
      LX_EXP: begin
        if (b == "+" || b == "-") begin
          phase = LX_EXP_SIGN;
        end else if (is_digit(b)) begin
          phase = LX_EXP_DIGIT;
        end else begin
          flag(jsv_pkg::ERR_INVALID);
        end
      end
      LX_EXP_SIGN: begin
        if (is_digit(b)) begin
          phase = LX_EXP_DIGIT;
        end else begin
          flag(jsv_pkg::ERR_INVALID);
        end
      end
      LX_LEAD_ZERO, LX_INT, LX_FRAC, LX_EXP_DIGIT: begin
        // Digits extend the number, except after a leading zero; anything else ends it or moves on.
        if (phase == LX_LEAD_ZERO || !is_digit(b)) begin
          if ((phase == LX_LEAD_ZERO || phase == LX_INT) && b == ".") begin
            phase = LX_POINT;
          end else if (phase != LX_EXP_DIGIT && (b == "e" || b == "E")) begin
            phase = LX_EXP;
          end else begin
            follow_value(b);
          end
        end
      end
      default: flag(jsv_pkg::ERR_INVALID);
    endcase
  endfunction

  function automatic void take_request(input logic [7:0] b, input logic last);
    jsv_pkg::err_e v;
    if (first_err == jsv_pkg::ERR_NONE) begin
      parse_byte(b);
    end
    if (last) begin
      v = first_err;
      if (v == jsv_pkg::ERR_NONE && (depth != 6'd0 ||
          !(phase == LX_AFTER || phase == LX_LEAD_ZERO || phase == LX_INT ||
            phase == LX_FRAC || phase == LX_EXP_DIGIT))) begin
        v = jsv_pkg::ERR_INVALID;
      end
      verdicts_due.push_back(v);
      clear_doc();
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    jsv_pkg::err_e want;
    if (!rst_ni) begin
      clear_doc();
      verdicts_due.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      // Retire the outgoing verdict before queuing one from this cycle's byte.
      if (m_tvalid_i && m_tready_i) begin
        if (verdicts_due.size() == 0) begin
          $error("verdict: expected none, got %0d", m_tdata_i[1:0]);
          fail_count_o++;
        end else begin
          want = verdicts_due.pop_front();
          if (m_tdata_i[1:0] !== want) begin
            $error("verdict: expected %0d, got %0d", want, m_tdata_i[1:0]);
            fail_count_o++;
          end
          if (m_tdata_i[7:2] !== 6'd0) begin
            $error("tdata pad: expected 0, got %0d", m_tdata_i[7:2]);
            fail_count_o++;
          end
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        take_request(s_tdata_i, s_tlast_i);
      end
      pending_o = verdicts_due.size();
    end
  end

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// Top of the JSON syntax validator testbench: builds byte documents, drives
// them with random gaps, paces the verdict channel and reports the outcome.
// Depends on json_syntax_validator and json_verdict_checker.
module tb_top;

  localparam int unsigned MaxNest     = 31;
  localparam int          RandomBytes = 950;
  localparam int          MinDocs     = 40;
  localparam int          HoldOff     = 150;
  localparam int          StallLimit  = 2000;
  localparam int          DrainCycles = 20;

  logic       clk      = 1'b0;
  logic       rst_n    = 1'b0;
  logic       s_tvalid = 1'b0;
  logic       s_tready;
  logic [7:0] s_tdata  = 8'h00;
  logic       s_tlast  = 1'b0;
  logic       m_tvalid;
  logic       m_tready = 1'b0;
  logic [7:0] m_tdata;

  int fail_count;
  int pending;
  int idle_cycles = 0;
  int bytes_sent  = 0;
  int docs_sent   = 0;

  logic [7:0] doc [$];
  string      json_chars = "{}[]\":,-+.eE0123456789tfnrulsa \\";

  json_syntax_validator #(
    .MAX_NEST (MaxNest)
  ) uut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tlast_i  (s_tlast),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)
  );

  json_verdict_checker #(
    .MAX_NEST (MaxNest)
  ) checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .s_tvalid_i   (s_tvalid),
    .s_tready_i   (s_tready),
    .s_tdata_i    (s_tdata),
    .s_tlast_i    (s_tlast),
    .m_tvalid_i   (m_tvalid),
    .m_tready_i   (m_tready),
    .m_tdata_i    (m_tdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void put_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      doc.push_back(s[i]);
    end
  endfunction

  function automatic void put_ws();
    int n;
    n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
    repeat (n) begin
      case ($urandom_range(0, 3))
        0:       doc.push_back(8'h09);
        1:       doc.push_back(8'h0A);
        2:       doc.push_back(8'h0D);
        default: doc.push_back(" ");
      endcase
    end
  endfunction

  function automatic logic [7:0] noise_byte();
    if ($urandom_range(0, 1) == 0) begin
      return 8'($urandom_range(0, 255));
    end
    return json_chars[$urandom_range(0, json_chars.len() - 1)];
  endfunction

  // Strings carry escapes of any byte, control bytes and bytes above 127.
  function automatic void put_string();
    int n;
    n = $urandom_range(0, 4);
    doc.push_back("\"");
    repeat (n) begin
      case ($urandom_range(0, 9))
        0: begin
          doc.push_back("\\");
          doc.push_back(8'($urandom_range(0, 255)));
        end
        1:       doc.push_back(8'($urandom_range(0, 31)));
        2:       doc.push_back(8'($urandom_range(128, 255)));
        default: doc.push_back(8'($urandom_range(97, 122)));
      endcase
    end
    doc.push_back("\"");
  endfunction

  function automatic void put_number();
    if ($urandom_range(0, 2) == 0) begin
      doc.push_back("-");
    end
    if ($urandom_range(0, 3) == 0) begin
      doc.push_back("0");
    end else begin
      doc.push_back(8'($urandom_range(49, 57)));
      repeat ($urandom_range(0, 2)) doc.push_back(8'($urandom_range(48, 57)));
    end
    if ($urandom_range(0, 2) == 0) begin
      doc.push_back(".");
      repeat ($urandom_range(1, 2)) doc.push_back(8'($urandom_range(48, 57)));
    end
    if ($urandom_range(0, 3) == 0) begin
      doc.push_back(($urandom_range(0, 1) == 0) ? "e" : "E");
      case ($urandom_range(0, 2))
        0:       doc.push_back("+");
        1:       doc.push_back("-");
        default: ;
      endcase
      repeat ($urandom_range(1, 2)) doc.push_back(8'($urandom_range(48, 57)));
    end
  endfunction

  function automatic void put_value(input int levels);
    int n;
    case ($urandom_range(0, (levels > 0) ? 7 : 4))
      0, 1: put_string();
      2, 3: put_number();
      4: begin
        case ($urandom_range(0, 2))
          0:       put_text("true");
          1:       put_text("false");
          default: put_text("null");
        endcase
      end
      5, 6: begin
        doc.push_back("[");
        put_ws();
        n = $urandom_range(0, 3);
        for (int i = 0; i < n; i++) begin
          if (i != 0) begin
            doc.push_back(",");
            put_ws();
          end
          put_value(levels - 1);
          put_ws();
        end
        doc.push_back("]");
      end
      default: begin
        doc.push_back("{");
        put_ws();
        n = $urandom_range(0, 3);
        for (int i = 0; i < n; i++) begin
          if (i != 0) begin
            doc.push_back(",");
            put_ws();
          end
          put_string();
          put_ws();
          doc.push_back(":");
          put_ws();
          put_value(levels - 1);
          put_ws();
        end
        doc.push_back("}");
      end
    endcase
  endfunction

  // Nest just below, at and beyond the depth bound.
  function automatic void put_deep();
    int levels;
    bit is_obj [40];
    levels = $urandom_range(29, 34);
    for (int i = 0; i < levels; i++) begin
      is_obj[i] = ($urandom_range(0, 6) == 0);
      if (is_obj[i]) begin
        put_text("{\"\":");
      end else begin
        doc.push_back("[");
      end
    end
    if ($urandom_range(0, 2) != 0) begin
      put_value(0);
    end
    for (int i = levels - 1; i >= 0; i--) begin
      doc.push_back(is_obj[i] ? "}" : "]");
    end
  endfunction

  function automatic void mutate_doc();
    int pos;
    pos = $urandom_range(0, doc.size() - 1);
    case ($urandom_range(0, 3))
      0: doc[pos] = noise_byte();
      1: begin
        if (doc.size() > 1) begin
          doc.delete(pos);
        end
      end
      2: begin
        while (doc.size() > pos + 1) doc.pop_back();
      end
      default: doc.insert(pos, noise_byte());
    endcase
  endfunction

  task automatic send_doc(input bit no_gaps);
    int gap;
    for (int i = 0; i < doc.size(); i++) begin
      gap = no_gaps ? 0 : $urandom_range(0, 12);
      @(negedge clk);
      if (gap != 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      s_tvalid <= 1'b1;
      s_tdata  <= doc[i];
      s_tlast  <= (i == doc.size() - 1);
      do @(posedge clk); while (!s_tready);
    end
    bytes_sent += doc.size();
    docs_sent++;
    doc.delete();
  endtask

  initial begin : stimulus
    int kind;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    put_text("0");
    send_doc(1'b0);
    doc.push_back(8'hFF);
    send_doc(1'b0);
    doc.push_back(8'h00);
    send_doc(1'b1);
    put_text(" ");
    send_doc(1'b0);
    put_text("[]");
    send_doc(1'b1);
    put_text("{}");
    send_doc(1'b0);
    put_text("-0.5E+7");
    send_doc(1'b1);
    put_text("\"\\\"");
    doc.push_back(8'h01);
    doc.push_back(8'h80);
    put_text("\"");
    send_doc(1'b0);
    put_text("nul");
    send_doc(1'b0);
    put_text("1 x]");
    send_doc(1'b1);
    put_text("[1,");
    send_doc(1'b0);

    bytes_sent = 0;
    docs_sent  = 0;
    put_deep();
    send_doc(1'b0);
    while (bytes_sent < RandomBytes || docs_sent < MinDocs) begin
      kind = $urandom_range(0, 99);
      if (kind < 85) begin
        put_ws();
        put_value($urandom_range(0, 2));
        put_ws();
        if (kind >= 70) begin
          mutate_doc();
          if ($urandom_range(0, 1) == 0) begin
            mutate_doc();
          end
        end
      end else if (kind < 93) begin
        repeat ($urandom_range(1, 6)) doc.push_back(noise_byte());
      end else if (kind < 97) begin
        put_deep();
      end else begin
        repeat ($urandom_range(1, 3)) doc.push_back(" ");
      end
      send_doc($urandom_range(0, 3) == 0);
    end

    @(negedge clk);
    s_tvalid <= 1'b0;
    wait (pending == 0);
    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Pace verdicts; twice hold off long enough for the block to back up.
  initial begin : verdict_sink
    int stall;
    int taken;
    taken = 0;
    @(posedge rst_n);
    forever begin
      if (taken == 2 || taken == 20) begin
        stall = HoldOff;
      end else begin
        stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
      end
      @(negedge clk);
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      taken++;
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= StallLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

endmodule
